// ===== sv/slt_pkg.sv =====
package slt_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
	localparam logic [7:0] INDEX_NONE = 8'hFF;

	typedef enum logic [2:0] {
		FN_INSERT    = 3'd0,
		FN_REMOVE    = 3'd1,
		FN_CONTAINS  = 3'd2,
		FN_REMOVE_AT = 3'd3,
		FN_READ_AT   = 3'd4,
		FN_INDEX_OF  = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// broadcast to every cell
	typedef struct packed {
		logic               fire;
		logic [2:0]         func;
		logic signed [31:0] value;
		logic [7:0]         index;
		logic [7:0]         count;
		logic               found;
		logic               full;
	} cell_ctl_t;

	// compare flags handed to the right neighbor
	typedef struct packed {
		logic vld;
		logic lt;
		logic eq;
		logic first;
	} cell_flag_t;

endpackage

// ===== sv/slt_if.sv =====
interface slt_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic signed [31:0] value;
	logic [7:0]         index;

	modport source (output valid, output func, output value, output index, input ready);
	modport sink (input valid, input func, input value, input index, output ready);
endinterface

interface slt_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] value_out;
	logic [7:0]         index_out;
	logic [4:0]         count_out;

	modport source (output valid, output status, output value_out, output index_out,
		output count_out, input ready);
	modport sink (input valid, input status, input value_out, input index_out,
		input count_out, output ready);
endinterface

// ===== sv/slt_cell.sv =====
module slt_cell #(
	parameter int POS = 0
) (
	input  logic                clk,
	input  slt_pkg::cell_ctl_t  ctl,
	input  slt_pkg::cell_flag_t left_flag,
	input  logic signed [31:0]  left_entry,
	input  logic signed [31:0]  right_entry,
	output logic signed [31:0]  entry,
	output slt_pkg::cell_flag_t flag
);
	import slt_pkg::*;

	localparam logic [7:0] POS_B = 8'(POS);
	localparam bit FIRST_CELL = (POS == 0);

	logic signed [31:0] entry_q;
	logic signed [31:0] entry_d;
	logic vld, lt, eq, left_le, ins_here, shift_r, idx_ok;

	always_comb begin
		vld      = POS_B < ctl.count;
		lt       = vld && (entry_q < ctl.value);
		eq       = vld && (entry_q == ctl.value);
		left_le  = left_flag.lt || left_flag.eq;
		ins_here = !(lt || eq) && (FIRST_CELL || left_le);
		shift_r  = left_flag.vld && !left_le;
		idx_ok   = ctl.index < ctl.count;
	end

	assign flag  = '{vld: vld, lt: lt, eq: eq, first: eq && !left_flag.eq};
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		unique case (ctl.func)
			FN_INSERT: begin
				if (!ctl.full) begin
					if (ins_here) begin
						entry_d = ctl.value;
					end else if (shift_r) begin
						entry_d = left_entry;
					end
				end
			end
			FN_REMOVE: begin
				if (ctl.found && vld && !lt) begin
					entry_d = right_entry;
				end
			end
			FN_REMOVE_AT: begin
				if (idx_ok && vld && (POS_B >= ctl.index)) begin
					entry_d = right_entry;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			entry_q <= entry_d;
		end
	end

endmodule

// ===== sv/sorted_list_table.sv =====
// channel  dir  words carried
// req      in   func, value, index
// rsp      out  status, value_out, index_out, count_out
//
// the word is registered first; the row of cells then compares against it and
// shifts or loads in place as the response is registered
// a new request is taken in the same cycle the previous one updates the row,
// so one word per cycle when rsp is not stalled
// a stalled rsp holds the pending request and the row; count clears on arst_n
module sorted_list_table #(
	parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
	input logic         clk,
	input logic         arst_n,
	slt_req_if.sink     req,
	slt_rsp_if.source   rsp
);
	import slt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic               busy_q;
	logic [2:0]         func_s1;
	logic signed [31:0] value_s1;
	logic [7:0]         index_s1;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;

	logic               rsp_vld_q;
	logic [1:0]         status_q;
	logic signed [31:0] value_out_q;
	logic [7:0]         index_out_q;

	logic               rsp_free, fire, full, found, idx_ok;
	logic [7:0]         pos_hit;
	logic signed [31:0] rd_entry;
	status_t            status_d;
	logic signed [31:0] value_out_d;
	logic [7:0]         index_out_d;

	cell_ctl_t          ctl;
	cell_flag_t         flag_w [CAPACITY];
	logic signed [31:0] entry_w [CAPACITY];

	assign rsp_free  = !rsp_vld_q || rsp.ready;
	assign fire      = busy_q && rsp_free;
	assign req.ready = !busy_q || rsp_free;
	assign full      = count_q >= CAP_C;
	assign idx_ok    = index_s1 < 8'(count_q);

	always_comb begin
		found    = 1'b0;
		pos_hit  = '0;
		rd_entry = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			found = found | flag_w[i].first;
			if (flag_w[i].first) begin
				pos_hit = pos_hit | 8'(i);
			end
			if (8'(i) == index_s1) begin
				rd_entry = rd_entry | entry_w[i];
			end
		end
	end

	assign ctl = '{fire: fire, func: func_s1, value: value_s1, index: index_s1,
		count: 8'(count_q), found: found, full: full};

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		cell_flag_t         lf;
		logic signed [31:0] le, re;
		if (g == 0) begin : g_first
			assign lf = '0;
			assign le = '0;
		end else begin : g_mid
			assign lf = flag_w[g-1];
			assign le = entry_w[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign re = entry_w[g];
		end else begin : g_inner
			assign re = entry_w[g+1];
		end
		slt_cell #(.POS(g)) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.left_flag   (lf),
			.left_entry  (le),
			.right_entry (re),
			.entry       (entry_w[g]),
			.flag        (flag_w[g])
		);
	end

	always_comb begin
		count_d     = count_q;
		status_d    = ST_MISS;
		value_out_d = '0;
		index_out_d = '0;
		unique case (func_s1)
			FN_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_OK;
					count_d  = CW'(count_q + 1'b1);
				end
			end
			FN_REMOVE: begin
				if (found) begin
					status_d = ST_OK;
					count_d  = CW'(count_q - 1'b1);
				end
			end
			FN_CONTAINS: begin
				if (found) begin
					status_d = ST_OK;
				end
			end
			FN_REMOVE_AT: begin
				if (idx_ok) begin
					status_d = ST_OK;
					count_d  = CW'(count_q - 1'b1);
				end
			end
			FN_READ_AT: begin
				if (idx_ok) begin
					status_d    = ST_OK;
					value_out_d = rd_entry;
				end else begin
					value_out_d = VALUE_MAX;
				end
			end
			FN_INDEX_OF: begin
				if (found) begin
					status_d    = ST_OK;
					index_out_d = pos_hit;
				end else begin
					index_out_d = INDEX_NONE;
				end
			end
			default: begin
				status_d = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rsp_vld_q <= 1'b0;
			count_q   <= '0;
		end else begin
			if (req.valid && req.ready) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				rsp_vld_q <= 1'b1;
				count_q   <= count_d;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1  <= req.func;
			value_s1 <= req.value;
			index_s1 <= req.index;
		end
		if (fire) begin
			status_q    <= status_d;
			value_out_q <= value_out_d;
			index_out_q <= index_out_d;
		end
	end

	assign rsp.valid     = rsp_vld_q;
	assign rsp.status    = status_q;
	assign rsp.value_out = value_out_q;
	assign rsp.index_out = index_out_q;
	assign rsp.count_out = 5'(count_q);

`ifndef SYNTHESIS
	logic [CAPACITY-1:0] first_vec;
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			first_vec[i] = flag_w[i].first;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("count above capacity");

	a_single_first: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(first_vec))
		else $error("more than one first match, row out of order");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (func_s1 == FN_INSERT) && !full |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("insert did not grow count");

	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !rsp_free |=> busy_q && $stable(count_q))
		else $error("pending word lost under stall");
`endif

endmodule
